// ----- rtl/core/assert_macros.svh -----
// concurrent assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds in the same cycle as its antecedent
`define SEQC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after its antecedent
`define SEQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SEQC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SEQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/seqc_pkg.sv -----
`default_nettype none

package seqc_pkg;

  localparam int CMD_W    = 3;
  localparam int OFFS_W   = 32;
  localparam int TOTAL_W  = 16;
  localparam int IDX_IN_W = 4;
  localparam int BYTE_W   = 8;
  localparam int PORT_A_W = 32;
  localparam int VAL_W    = 28;
  localparam int SEEN_W   = 2;

  localparam int              VLQ_CONT_BIT = 7;
  localparam logic [SEEN_W-1:0] VLQ_LAST_SEEN = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART  = 3'd0,
    CMD_CALL     = 3'd1,
    CMD_LOOP_BEG = 3'd2,
    CMD_LOOP_END = 3'd3,
    CMD_RETURN   = 3'd4,
    CMD_PEEK     = 3'd5,
    CMD_VALUE    = 3'd6
  } cmd_t;

  // controller to datapath strobes
  typedef struct packed {
    logic cap;
    logic rd;
    logic exe;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/seqc_if.sv -----
`default_nettype none

interface seqc_in_if;
  logic                               valid;
  logic                               ready;
  logic [seqc_pkg::CMD_W-1:0]         cmd;
  logic [seqc_pkg::OFFS_W-1:0]        target_offset;
  logic [seqc_pkg::TOTAL_W-1:0]       loop_total;
  logic [seqc_pkg::IDX_IN_W-1:0]      entry_index;
  logic [seqc_pkg::BYTE_W-1:0]        data_byte;

  modport source (output valid, cmd, target_offset, loop_total, entry_index, data_byte,
                  input ready);
  modport sink   (input valid, cmd, target_offset, loop_total, entry_index, data_byte,
                  output ready);
endinterface

interface seqc_out_if #(
  parameter int DEPTH_W = 4
);
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [seqc_pkg::PORT_A_W-1:0]  cursor_now;
  logic [DEPTH_W-1:0]             stack_depth;
  logic [seqc_pkg::PORT_A_W-1:0]  entry_address;
  logic                           value_done;
  logic [seqc_pkg::VAL_W-1:0]     value_out;

  modport source (output valid, ok, cursor_now, stack_depth, entry_address, value_done,
                  value_out, input ready);
  modport sink   (input valid, ok, cursor_now, stack_depth, entry_address, value_done,
                  value_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sequence_cursor_call_loop_stack.sv -----
// channel | dir | words carried
// --------+-----+-------------------------------------------------------------
// in_ch   | in  | cmd, target_offset, loop_total, entry_index, data_byte
// out_ch  | out | ok, cursor_now, stack_depth, entry_address, value_done, value_out
// cfg_*   | in  | buffer_base, written whenever cfg_we is high
//
// each word passes through capture, stack memory read, then update and result load
// one word is in flight at a time; the stack read is registered before the update uses it
// a held result stalls the update cycle until out_ch takes it
// synchronous active-low reset: cursor, depth, decoder and count valid bits cleared
`default_nettype none

`include "assert_macros.svh"

module sequence_cursor_call_loop_stack #(
  parameter int STACK_DEPTH = 8,
  parameter int ADDR_WIDTH  = 32,
  parameter int DEPTH_W     = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [seqc_pkg::PORT_A_W-1:0] cfg_wdata,
  seqc_in_if.sink                            in_ch,
  seqc_out_if.source                         out_ch
);

  seqc_pkg::ctl_t ctl;

  seqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  seqc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .DEPTH_W     (DEPTH_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_ch.cmd),
    .in_target_offset  (in_ch.target_offset),
    .in_loop_total     (in_ch.loop_total),
    .in_entry_index    (in_ch.entry_index),
    .in_data_byte      (in_ch.data_byte),
    .out_ok            (out_ch.ok),
    .out_cursor_now    (out_ch.cursor_now),
    .out_stack_depth   (out_ch.stack_depth),
    .out_entry_address (out_ch.entry_address),
    .out_value_done    (out_ch.value_done),
    .out_value_out     (out_ch.value_out)
  );

  `SEQC_ASSERT_SAME(a_depth_bound, clk, rst_n, out_ch.valid,
                    out_ch.stack_depth <= DEPTH_W'(STACK_DEPTH), "stack depth beyond capacity")
  `SEQC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready,
                    "second word taken while one is in flight")
  `SEQC_ASSERT_SAME(a_done_ok, clk, rst_n, out_ch.valid && out_ch.value_done, out_ch.ok,
                    "value completed on a failed word")

endmodule

`default_nettype wire

// ----- rtl/core/seqc_ctrl.sv -----
`default_nettype none

module seqc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      seqc_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cap   = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // result register must be free before the update commits
        if (out_free) begin
          ctl.exe   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.exe) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/seqc_dp.sv -----
`default_nettype none

module seqc_dp #(
  parameter int STACK_DEPTH = 8,
  parameter int ADDR_WIDTH  = 32,
  parameter int DEPTH_W     = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire seqc_pkg::ctl_t                    ctl,
  input  wire logic                              cfg_we,
  input  wire logic [seqc_pkg::PORT_A_W-1:0]     cfg_wdata,
  input  wire logic [seqc_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [seqc_pkg::OFFS_W-1:0]       in_target_offset,
  input  wire logic [seqc_pkg::TOTAL_W-1:0]      in_loop_total,
  input  wire logic [seqc_pkg::IDX_IN_W-1:0]     in_entry_index,
  input  wire logic [seqc_pkg::BYTE_W-1:0]       in_data_byte,
  output      logic                              out_ok,
  output      logic [seqc_pkg::PORT_A_W-1:0]     out_cursor_now,
  output      logic [DEPTH_W-1:0]                out_stack_depth,
  output      logic [seqc_pkg::PORT_A_W-1:0]     out_entry_address,
  output      logic                              out_value_done,
  output      logic [seqc_pkg::VAL_W-1:0]        out_value_out
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CMP_W = 8;

  // configuration and architectural state
  logic [seqc_pkg::PORT_A_W-1:0] base_r;
  logic [ADDR_WIDTH-1:0]         cursor_r, cursor_nxt;
  logic [DEPTH_W-1:0]            depth_r, depth_nxt;
  logic [seqc_pkg::VAL_W-1:0]    accum_r, accum_nxt;
  logic [seqc_pkg::SEEN_W-1:0]   seen_r, seen_nxt;
  logic                          busy_r, busy_nxt;

  // captured word
  seqc_pkg::cmd_t                cmd_r;
  logic [seqc_pkg::OFFS_W-1:0]   offs_r;
  logic [seqc_pkg::TOTAL_W-1:0]  total_r;
  logic [seqc_pkg::IDX_IN_W-1:0] idx_r;
  logic [seqc_pkg::BYTE_W-1:0]   byte_r;

  // stack storage
  logic [ADDR_WIDTH-1:0]            sav_mem [STACK_DEPTH];
  logic [seqc_pkg::TOTAL_W-1:0]     cnt_mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0]           cnt_vld_r;
  logic [ADDR_WIDTH-1:0]            rd_sav_r;
  logic [seqc_pkg::TOTAL_W-1:0]     rd_cnt_r;
  logic                             rd_vld_r;
  logic [IDX_W-1:0]                 rd_addr, wr_addr, top_idx, push_idx;
  logic                             sav_we, cnt_we;
  logic [ADDR_WIDTH-1:0]            sav_wdata;
  logic [seqc_pkg::TOTAL_W-1:0]     cnt_wdata;

  // result
  logic                             ok_c, done_c;
  logic [ADDR_WIDTH-1:0]            entry_c;
  logic [seqc_pkg::VAL_W-1:0]       val_c, acc_sh;
  logic                             full, empty, idx_hit;
  logic [seqc_pkg::OFFS_W:0]        call_sum;
  logic [seqc_pkg::TOTAL_W-1:0]     cnt_top, cnt_dec;

  assign full     = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign empty    = (depth_r == '0);
  assign top_idx  = IDX_W'(depth_r - DEPTH_W'(1));
  assign push_idx = IDX_W'(depth_r);
  assign idx_hit  = (CMP_W'(idx_r) < CMP_W'(depth_r));
  assign rd_addr  = (cmd_r == seqc_pkg::CMD_PEEK) ? IDX_W'(idx_r) : top_idx;
  assign call_sum = (seqc_pkg::OFFS_W + 1)'(base_r) + (seqc_pkg::OFFS_W + 1)'(offs_r);
  assign acc_sh   = {accum_r[seqc_pkg::VAL_W-8:0], byte_r[6:0]};
  // a count slot never written by a loop start reads as zero; a call keeps the old count
  assign cnt_top  = rd_vld_r ? rd_cnt_r : '0;
  assign cnt_dec  = (cnt_top != '0) ? cnt_top - 1'b1 : cnt_top;

  always_comb begin
    ok_c       = 1'b1;
    done_c     = 1'b0;
    entry_c    = '0;
    val_c      = '0;
    cursor_nxt = cursor_r;
    depth_nxt  = depth_r;
    accum_nxt  = accum_r;
    seen_nxt   = seen_r;
    busy_nxt   = busy_r;
    sav_we     = 1'b0;
    cnt_we     = 1'b0;
    wr_addr    = push_idx;
    sav_wdata  = cursor_r;
    cnt_wdata  = total_r;
    case (cmd_r)
      seqc_pkg::CMD_RESTART: begin
        cursor_nxt = ADDR_WIDTH'(base_r);
        depth_nxt  = '0;
        accum_nxt  = '0;
        seen_nxt   = '0;
        busy_nxt   = 1'b0;
      end
      seqc_pkg::CMD_CALL: begin
        if (full) begin
          ok_c = 1'b0;
        end else begin
          sav_we     = 1'b1;
          depth_nxt  = depth_r + 1'b1;
          cursor_nxt = ADDR_WIDTH'(call_sum);
        end
      end
      seqc_pkg::CMD_LOOP_BEG: begin
        if (full) begin
          ok_c = 1'b0;
        end else begin
          sav_we    = 1'b1;
          cnt_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
      seqc_pkg::CMD_LOOP_END: begin
        if (empty) begin
          ok_c = 1'b0;
        end else if (cnt_dec == '0) begin
          depth_nxt = depth_r - 1'b1;
        end else begin
          cnt_we     = 1'b1;
          wr_addr    = top_idx;
          cnt_wdata  = cnt_dec;
          cursor_nxt = rd_sav_r;
        end
      end
      seqc_pkg::CMD_RETURN: begin
        if (empty) begin
          ok_c = 1'b0;
        end else begin
          depth_nxt  = depth_r - 1'b1;
          cursor_nxt = rd_sav_r;
        end
      end
      seqc_pkg::CMD_PEEK: begin
        if (idx_hit) begin
          entry_c = rd_sav_r;
        end
      end
      seqc_pkg::CMD_VALUE: begin
        cursor_nxt = cursor_r + 1'b1;
        if (!busy_r) begin
          if (!byte_r[seqc_pkg::VLQ_CONT_BIT]) begin
            done_c = 1'b1;
            val_c  = seqc_pkg::VAL_W'(byte_r);
          end else begin
            accum_nxt = seqc_pkg::VAL_W'(byte_r[6:0]);
            seen_nxt  = seqc_pkg::SEEN_W'(1);
            busy_nxt  = 1'b1;
          end
        end else if (!byte_r[seqc_pkg::VLQ_CONT_BIT]) begin
          done_c    = 1'b1;
          val_c     = acc_sh;
          accum_nxt = '0;
          seen_nxt  = '0;
          busy_nxt  = 1'b0;
        end else if (seen_r == seqc_pkg::VLQ_LAST_SEEN) begin
          // fourth byte still continues: overlong, value forced to zero
          done_c    = 1'b1;
          accum_nxt = '0;
          seen_nxt  = '0;
          busy_nxt  = 1'b0;
        end else begin
          accum_nxt = acc_sh;
          seen_nxt  = seen_r + 1'b1;
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      cursor_r  <= '0;
      depth_r   <= '0;
      accum_r   <= '0;
      seen_r    <= '0;
      busy_r    <= 1'b0;
      cnt_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (ctl.exe) begin
        cursor_r <= cursor_nxt;
        depth_r  <= depth_nxt;
        accum_r  <= accum_nxt;
        seen_r   <= seen_nxt;
        busy_r   <= busy_nxt;
        if (cnt_we) begin
          cnt_vld_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r   <= seqc_pkg::cmd_t'(in_cmd);
      offs_r  <= in_target_offset;
      total_r <= in_loop_total;
      idx_r   <= in_entry_index;
      byte_r  <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exe && sav_we) begin
      sav_mem[wr_addr] <= sav_wdata;
    end
    if (ctl.exe && cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_sav_r <= sav_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
      rd_vld_r <= cnt_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exe) begin
      out_ok            <= ok_c;
      out_cursor_now    <= seqc_pkg::PORT_A_W'(cursor_nxt);
      out_stack_depth   <= depth_nxt;
      out_entry_address <= seqc_pkg::PORT_A_W'(entry_c);
      out_value_done    <= done_c;
      out_value_out     <= val_c;
    end
  end

endmodule

`default_nettype wire
